FILE: src/smap_pkg.sv
// shared types and constants for the stun mapped-address parser
// no dependencies
package smap_pkg;

  localparam int unsigned DefMaxMessageBytes = 2048;
  localparam logic [31:0] StunCookie = 32'h2112A442;
  localparam logic [15:0] AttrMapped = 16'h0001;
  localparam logic [15:0] AttrXorMapped = 16'h0020;
  localparam logic [4:0] HeaderBytes = 5'd20;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusZeroLen = 2'd1;
  localparam logic [1:0] StatusNoMapped = 2'd2;
  localparam logic [1:0] StatusBadFamily = 2'd3;

  localparam logic [7:0] FamilyV4 = 8'd1;
  localparam logic [7:0] FamilyV6 = 8'd2;

  localparam logic [2:0] RegHeaderInStream = 3'd0;
  localparam logic [2:0] RegLocalPort = 3'd1;
  localparam logic [2:0] RegTid0 = 3'd2;
  localparam logic [2:0] RegTid1 = 3'd3;
  localparam logic [2:0] RegTid2 = 3'd4;

  typedef enum logic [2:0] {
    PhSkip,
    PhAhdr,
    PhValue,
    PhPad,
    PhDone
  } phase_e;

  // end-of-message capture handed from the parser to the result stage
  typedef struct packed {
    logic        err;
    logic        found;
    logic        is_xor;
    logic [7:0]  family;
    logic [15:0] port;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
  } capture_t;

  localparam int unsigned CaptureW = $bits(capture_t);

endpackage

FILE: src/smap_parser.sv
// front part: walks message bytes and captures the first mapped address
// depends on smap_pkg
module smap_parser
  import smap_pkg::*;
#(
  parameter int unsigned MaxMessageBytes = DefMaxMessageBytes
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  logic     header_in_stream_i,
  input  logic [7:0] data_byte_i,
  input  logic     last_byte_i,
  output logic     done_o,
  output capture_t cap_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] offset_q, offset_d;
  logic [15:0] atype_q, atype_d;
  logic [15:0] alen_q, alen_d;
  logic [15:0] fidx_q, fidx_d;
  capture_t    cap_q, cap_d;
  logic [15:0] fidx_inc;
  logic [15:0] k;
  logic [1:0]  pad;
  phase_e      ph;

  assign fidx_inc = (offset_q == 16'd0 ? 16'd0 : fidx_q) + 16'd1;
  assign k = fidx_q - 16'd4;

  always_comb begin
    phase_d = phase_q;
    offset_d = offset_q;
    atype_d = atype_q;
    alen_d = alen_q;
    fidx_d = fidx_q;
    cap_d = cap_q;
    cap_o = cap_q;
    ph = phase_q;
    pad = 2'd0;
    done_o = 1'b0;
    if (valid_i) begin
      if (offset_q == 16'd0) begin
        ph = header_in_stream_i ? PhSkip : PhAhdr;
        phase_d = ph;
        fidx_d = 16'd0;
      end
      if (offset_q < 16'(MaxMessageBytes)) begin
        case (ph)
          PhSkip: begin
            fidx_d = fidx_inc;
            if (fidx_inc >= 16'(HeaderBytes)) begin
              phase_d = PhAhdr;
              fidx_d = 16'd0;
            end
          end
          PhAhdr: begin
            if (fidx_inc <= 16'd2) atype_d = {atype_q[7:0], data_byte_i};
            else alen_d = {alen_q[7:0], data_byte_i};
            fidx_d = fidx_inc;
            if (fidx_inc == 16'd4) begin
              fidx_d = 16'd0;
              if (alen_d == 16'd0) begin
                cap_d.err = 1'b1;
                phase_d = PhDone;
              end else begin
                if (atype_q == AttrMapped) cap_d.found = 1'b1;
                else if (atype_q == AttrXorMapped) begin
                  cap_d.found = 1'b1;
                  cap_d.is_xor = 1'b1;
                end
                phase_d = PhValue;
              end
            end
          end
          PhValue: begin
            if (cap_q.found) begin
              if (fidx_q == 16'd1) cap_d.family = data_byte_i;
              else if (fidx_q == 16'd2 || fidx_q == 16'd3)
                cap_d.port = {cap_q.port[7:0], data_byte_i};
              else if (fidx_q >= 16'd4 && fidx_q < 16'd20) begin
                if (!k[3]) cap_d.addr_hi[8*(7-k[2:0]) +: 8] = data_byte_i;
                else cap_d.addr_lo[8*(7-k[2:0]) +: 8] = data_byte_i;
              end
            end
            fidx_d = fidx_inc;
            if (fidx_inc >= alen_q) begin
              if (cap_q.found) phase_d = PhDone;
              else begin
                pad = 2'(3'd4 - {1'b0, alen_q[1:0]});
                fidx_d = 16'd0;
                atype_d = 16'd0;
                alen_d = {14'd0, pad};
                phase_d = (pad != 2'd0) ? PhPad : PhAhdr;
              end
            end
          end
          PhPad: begin
            fidx_d = fidx_inc;
            if (fidx_inc >= alen_q) begin
              fidx_d = 16'd0;
              alen_d = 16'd0;
              phase_d = PhAhdr;
            end
          end
          default: ;
        endcase
      end
      if (offset_q != 16'hFFFF) offset_d = offset_q + 16'd1;
      // result sees this byte's capture
      cap_o = cap_d;
      if (last_byte_i) begin
        done_o = 1'b1;
        phase_d = PhSkip;
        offset_d = 16'd0;
        atype_d = 16'd0;
        alen_d = 16'd0;
        fidx_d = 16'd0;
        cap_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSkip;
      offset_q <= '0;
      atype_q <= '0;
      alen_q <= '0;
      fidx_q <= '0;
      cap_q <= '0;
    end else begin
      phase_q <= phase_d;
      offset_q <= offset_d;
      atype_q <= atype_d;
      alen_q <= alen_d;
      fidx_q <= fidx_d;
      cap_q <= cap_d;
    end
  end

endmodule

FILE: src/smap_fifo.sv
// small queue between parser and result stage
// depends on smap_pkg
module smap_fifo
  import smap_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  capture_t data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output capture_t data_o
);

  capture_t   mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, rp_q;

  assign full_o = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o = mem_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 2'd1;
    else if (!push_i && pop_i) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q <= 1'b0;
      rp_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
    end
  end

endmodule

FILE: src/smap_result.sv
// back part: unmasks the capture, checks for change, holds the result
// depends on smap_pkg
module smap_result
  import smap_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  capture_t    cap_i,
  output logic        take_o,
  input  logic [15:0] local_port_i,
  input  logic [31:0] tid0_i,
  input  logic [31:0] tid1_i,
  input  logic [31:0] tid2_i,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [1:0]  status_o,
  output logic        addr_family_o,
  output logic [15:0] mapped_port_o,
  output logic [63:0] addr_high_o,
  output logic [63:0] addr_low_o,
  output logic        changed_o
);

  logic        full_q;
  logic [1:0]  st;
  logic        fam, chg;
  logic [15:0] port;
  logic [63:0] hi, lo;
  logic [63:0] prev_hi_q, prev_lo_q;
  logic [31:0] prev_ports_q;

  assign empty_o = !full_q;
  assign take_o = valid_i && (!full_q || pop_i);

  always_comb begin
    st = StatusOk;
    fam = 1'b0;
    port = '0;
    hi = '0;
    lo = '0;
    chg = 1'b0;
    if (cap_i.err) st = StatusZeroLen;
    else if (!cap_i.found) st = StatusNoMapped;
    else if (cap_i.family != FamilyV4 && cap_i.family != FamilyV6) st = StatusBadFamily;
    else begin
      port = cap_i.port ^ (cap_i.is_xor ? StunCookie[31:16] : 16'd0);
      hi = cap_i.addr_hi ^ (cap_i.is_xor ? {StunCookie, 32'd0} : 64'd0);
      lo = cap_i.addr_lo;
      if (cap_i.family == FamilyV4) begin
        hi = {hi[63:32], 32'd0};
        lo = '0;
      end else begin
        fam = 1'b1;
        if (cap_i.is_xor) begin
          hi = hi ^ {32'd0, tid0_i};
          lo = lo ^ {tid1_i, tid2_i};
        end
      end
      chg = ({local_port_i, port} != prev_ports_q) || (hi != prev_hi_q)
            || (lo != prev_lo_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      status_o <= st;
      addr_family_o <= fam;
      mapped_port_o <= port;
      addr_high_o <= hi;
      addr_low_o <= lo;
      changed_o <= chg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      prev_hi_q <= '0;
      prev_lo_q <= '0;
      prev_ports_q <= '0;
    end else begin
      if (take_o) full_q <= 1'b1;
      else if (pop_i) full_q <= 1'b0;
      if (take_o && st == StatusOk) begin
        prev_hi_q <= hi;
        prev_lo_q <= lo;
        prev_ports_q <= {local_port_i, port};
      end
    end
  end

endmodule

FILE: src/stun_mapped_address_parser.sv
// top level of the stun mapped-address parser
// depends on smap_pkg, smap_parser, smap_fifo, smap_result
//
// usage: message bytes enter on the push side, one request per byte, with
// last_byte_i marking the end of a message. each message gives one result
// (status, family, port, address, changed) on the pop side.
// the parser takes one byte per cycle while full_o is low; on the last
// byte its capture goes into a two-entry queue and the result stage
// unmasks it and registers it in an output slot once the slot is empty
// or being popped; from that slot the result is on the pop side.
// throughput is one byte per cycle while full_o is low, bounded by the parser's byte loop.
// full_o rises only when the queue holds two finished messages and the
// output slot is occupied; then every byte is held off until a pop.
// configuration goes through the apb port; the user must do it only while the block is idle (not enforced).
// reset (rst_ni low) clears the parse state, queue, output slot and the
// stored previous mapping; registers return to header skipping on.
module stun_mapped_address_parser
  import smap_pkg::*;
#(
  parameter int unsigned MaxMessageBytes = DefMaxMessageBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [1:0]  status_o,
  output logic        addr_family_o,
  output logic [15:0] mapped_port_o,
  output logic [63:0] addr_high_o,
  output logic [63:0] addr_low_o,
  output logic        changed_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        hdr_q;
  logic [15:0] lport_q;
  logic [31:0] tid0_q, tid1_q, tid2_q;
  logic        wr;
  logic [2:0]  ridx;
  logic        acc, done, q_full, q_empty, take;
  capture_t    cap, qcap;

  // register file
  assign pready = 1'b1;
  assign ridx = paddr[4:2];
  assign wr = psel && penable && pwrite;

  always_comb begin
    case (ridx)
      RegHeaderInStream: prdata = {31'd0, hdr_q};
      RegLocalPort:      prdata = {16'd0, lport_q};
      RegTid0:           prdata = tid0_q;
      RegTid1:           prdata = tid1_q;
      RegTid2:           prdata = tid2_q;
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q <= 1'b1;
      lport_q <= '0;
      tid0_q <= '0;
      tid1_q <= '0;
      tid2_q <= '0;
    end else if (wr) begin
      case (ridx)
        RegHeaderInStream: hdr_q <= pwdata[0];
        RegLocalPort:      lport_q <= pwdata[15:0];
        RegTid0:           tid0_q <= pwdata;
        RegTid1:           tid1_q <= pwdata;
        RegTid2:           tid2_q <= pwdata;
        default: ;
      endcase
    end
  end

  // any byte waits while the queue is full
  assign full_o = q_full;
  assign acc = push_i && !q_full;

  smap_parser #(.MaxMessageBytes(MaxMessageBytes)) u_parser (
    .clk_i, .rst_ni,
    .valid_i(acc),
    .header_in_stream_i(hdr_q),
    .data_byte_i, .last_byte_i,
    .done_o(done),
    .cap_o(cap)
  );

  smap_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(done), .data_i(cap), .full_o(q_full),
    .pop_i(take), .empty_o(q_empty), .data_o(qcap)
  );

  smap_result u_result (
    .clk_i, .rst_ni,
    .valid_i(!q_empty), .cap_i(qcap), .take_o(take),
    .local_port_i(lport_q), .tid0_i(tid0_q), .tid1_i(tid1_q), .tid2_i(tid2_q),
    .pop_i, .empty_o,
    .status_o, .addr_family_o, .mapped_port_o, .addr_high_o, .addr_low_o,
    .changed_o
  );

endmodule

FILE: verif/tb_stun_mapped_address_parser.sv
// testbench for the stun mapped-address parser: drives binding responses byte by byte,
// predicts each result with a behavioral model of the parser and checks it field by field
// depends on smap_pkg and the stun_mapped_address_parser rtl
module tb_stun_mapped_address_parser;
  import smap_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxBytes = DefMaxMessageBytes;

  logic        clk_i;
  logic        rst_ni;
  logic        push_i;
  logic        full_o;
  logic [7:0]  data_byte_i;
  logic        last_byte_i;
  logic        pop_i;
  logic        empty_o;
  logic [1:0]  status_o;
  logic        addr_family_o;
  logic [15:0] mapped_port_o;
  logic [63:0] addr_high_o;
  logic [63:0] addr_low_o;
  logic        changed_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  stun_mapped_address_parser uut (.*);

  // one mapped-address result as seen on the pop side
  typedef struct packed {
    logic [1:0]  status;
    logic        family;
    logic [15:0] port;
    logic [63:0] hi;
    logic [63:0] lo;
    logic        changed;
  } mapping_t;

  mapping_t pending_mappings[$];
  int       mismatches;
  int       send_idle_pct;
  int       recv_idle_pct;

  // predictor copy of the registers and parse state
  logic        cfg_skip_header;
  logic [15:0] cfg_local_port;
  logic [31:0] cfg_tid[3];
  phase_e      ph;
  logic [15:0] msg_off;
  logic [15:0] a_type;
  logic [15:0] a_len;
  logic [15:0] f_idx;
  logic [7:0]  cap_fam;
  logic [15:0] cap_port;
  logic [63:0] cap_addr[2];
  logic        fl_found;
  logic        fl_xor;
  logic        fl_err;
  logic [63:0] prev_addr[2];
  logic [31:0] prev_ports;

  function automatic void clear_message();
    ph = PhSkip;
    msg_off = '0;
    a_type = '0;
    a_len = '0;
    f_idx = '0;
    cap_fam = '0;
    cap_port = '0;
    cap_addr[0] = '0;
    cap_addr[1] = '0;
    fl_found = 1'b0;
    fl_xor = 1'b0;
    fl_err = 1'b0;
  endfunction

  function automatic void parse_one(logic [7:0] b);
    logic [15:0] pad;
    int          k;
    case (ph)
      PhSkip: begin
        f_idx++;
        if (f_idx >= 16'(HeaderBytes)) begin
          ph = PhAhdr;
          f_idx = '0;
        end
      end
      PhAhdr: begin
        if (f_idx < 2) a_type = {a_type[7:0], b};
        else a_len = {a_len[7:0], b};
        f_idx++;
        if (f_idx == 4) begin
          f_idx = '0;
          if (a_len == 0) begin
            fl_err = 1'b1;
            ph = PhDone;
          end else begin
            if (a_type == AttrMapped) fl_found = 1'b1;
            else if (a_type == AttrXorMapped) begin
              fl_found = 1'b1;
              fl_xor = 1'b1;
            end
            ph = PhValue;
          end
        end
      end
      PhValue: begin
        if (fl_found) begin
          if (f_idx == 1) cap_fam = b;
          else if (f_idx == 2 || f_idx == 3) cap_port = {cap_port[7:0], b};
          else if (f_idx >= 4 && f_idx < 20) begin
            k = f_idx - 4;
            cap_addr[k/8] |= 64'(b) << (8 * (7 - k % 8));
          end
        end
        f_idx++;
        if (f_idx >= a_len) begin
          if (fl_found) ph = PhDone;
          else begin
            pad = (16'd4 - (a_len & 16'd3)) & 16'd3;
            f_idx = '0;
            a_type = '0;
            a_len = pad;
            ph = (pad != 0) ? PhPad : PhAhdr;
          end
        end
      end
      PhPad: begin
        f_idx++;
        if (f_idx >= a_len) begin
          f_idx = '0;
          a_len = '0;
          ph = PhAhdr;
        end
      end
      default: ;
    endcase
  endfunction

  // forms the result at the end of a message and, for an ok status, updates the previous mapping
  function automatic mapping_t close_message();
    mapping_t    r;
    logic [31:0] ports;
    r = '0;
    if (fl_err) r.status = StatusZeroLen;
    else if (!fl_found) r.status = StatusNoMapped;
    else if (cap_fam != FamilyV4 && cap_fam != FamilyV6) r.status = StatusBadFamily;
    else begin
      r.status = StatusOk;
      r.port = cap_port;
      r.hi = cap_addr[0];
      r.lo = cap_addr[1];
      if (fl_xor) begin
        r.port ^= StunCookie[31:16];
        r.hi ^= {StunCookie, 32'h0};
      end
      if (cap_fam == FamilyV4) begin
        r.hi[31:0] = '0;
        r.lo = '0;
      end else begin
        r.family = 1'b1;
        if (fl_xor) begin
          r.hi ^= {32'h0, cfg_tid[0]};
          r.lo ^= {cfg_tid[1], cfg_tid[2]};
        end
      end
      ports = {cfg_local_port, r.port};
      r.changed = (ports != prev_ports) || (r.hi != prev_addr[0]) || (r.lo != prev_addr[1]);
      prev_ports = ports;
      prev_addr[0] = r.hi;
      prev_addr[1] = r.lo;
    end
    clear_message();
    return r;
  endfunction

  // feeds one accepted byte to the predictor
  function automatic void predict_byte(logic [7:0] b, logic last);
    if (msg_off == 0) begin
      ph = cfg_skip_header ? PhSkip : PhAhdr;
      f_idx = '0;
    end
    if (msg_off < MaxBytes) parse_one(b);
    if (msg_off != 16'hFFFF) msg_off++;
    if (last) pending_mappings.push_back(close_message());
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #30ms;
    $display("tb_stun_mapped_address_parser failed");
    $finish;
  end

  // receiver: random pop, check against the oldest expected mapping
  always @(posedge clk_i) begin
    mapping_t want;
    if (rst_ni) begin
      if (pop_i && !empty_o) begin
        if (pending_mappings.size() == 0) begin
          $display("mismatch: unexpected result at %0t", $realtime);
          mismatches++;
        end else begin
          want = pending_mappings.pop_front();
          if (status_o != want.status)
            report("status", 64'(status_o), 64'(want.status));
          if (addr_family_o != want.family)
            report("family", 64'(addr_family_o), 64'(want.family));
          if (mapped_port_o != want.port)
            report("port", 64'(mapped_port_o), 64'(want.port));
          if (addr_high_o != want.hi) report("addr_high", addr_high_o, want.hi);
          if (addr_low_o != want.lo) report("addr_low", addr_low_o, want.lo);
          if (changed_o != want.changed)
            report("changed", 64'(changed_o), 64'(want.changed));
        end
      end
      pop_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // pushes one byte request, with random idle cycles in front
  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (full_o);
    predict_byte(b, last);
  endtask

  task automatic send_msg(logic [7:0] bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    case (idx)
      RegHeaderInStream: cfg_skip_header = val[0];
      RegLocalPort: cfg_local_port = val[15:0];
      RegTid0: cfg_tid[0] = val;
      RegTid1: cfg_tid[1] = val;
      RegTid2: cfg_tid[2] = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    push_i <= 1'b0;
    while (pending_mappings.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  // builds a response: optional header, optional junk attrs, then an address attr, a zero-length attr or noise bytes
  function automatic void build_msg(ref logic [7:0] m[$], input logic hdr);
    int n_junk;
    int len;
    int kind;
    logic [15:0] t;
    m = {};
    if (hdr) repeat (20) m.push_back(8'($urandom));
    n_junk = $urandom_range(2);
    repeat (n_junk) begin
      len = $urandom_range(1, 7);
      t = ($urandom_range(3) == 0) ? 16'($urandom) : 16'h8022;
      m.push_back(t[15:8]); m.push_back(t[7:0]);
      m.push_back(8'h00); m.push_back(8'(len));
      repeat ((len + 3) / 4 * 4) m.push_back(8'($urandom));
    end
    kind = $urandom_range(19);
    if (kind == 0) begin
      // zero-length attribute
      m.push_back(8'($urandom)); m.push_back(8'($urandom));
      m.push_back(8'h00); m.push_back(8'h00);
    end else if (kind == 1) begin
      // no mapped address at all, maybe a cut header
      repeat ($urandom_range(3)) m.push_back(8'($urandom));
    end else if (kind == 2) begin
      // pure noise bytes
      repeat ($urandom_range(1, 40)) m.push_back(8'($urandom));
    end else begin
      t = $urandom_range(1) ? AttrXorMapped : AttrMapped;
      case ($urandom_range(9))
        0: len = $urandom_range(1, 7);
        1: len = 8;
        default: len = ($urandom_range(1)) ? 8 : 20;
      endcase
      if ($urandom_range(9) == 0) len = $urandom_range(1, 255);
      m.push_back(t[15:8]); m.push_back(t[7:0]);
      m.push_back(8'(len >> 8)); m.push_back(8'(len));
      m.push_back(8'($urandom));
      case ($urandom_range(9))
        0: m.push_back(8'($urandom));
        1, 2, 3, 4: m.push_back(FamilyV4);
        default: m.push_back(FamilyV6);
      endcase
      repeat (len - 2) m.push_back(8'($urandom));
      if ($urandom_range(7) == 0) repeat ($urandom_range(1, 12)) m.push_back(8'($urandom));
      if ($urandom_range(9) == 0) repeat ($urandom_range(1, len)) void'(m.pop_back());
    end
    if (m.size() == 0) m.push_back(8'($urandom));
  endfunction

  initial begin
    logic [7:0] msg[$];
    logic [7:0] v6[$];
    int k;
    mismatches = 0;
    send_idle_pct = 25;
    recv_idle_pct = 83;
    rst_ni = 1'b0;
    push_i = 1'b0;
    data_byte_i = '0;
    last_byte_i = 1'b0;
    pop_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_skip_header = 1'b1;
    cfg_local_port = '0;
    cfg_tid[0] = '0;
    cfg_tid[1] = '0;
    cfg_tid[2] = '0;
    prev_addr[0] = '0;
    prev_addr[1] = '0;
    prev_ports = '0;
    clear_message();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: header skipped by reset default, single last byte -> no mapped address
    send_msg('{8'hFF});
    // cut attribute header
    msg = {}; repeat (22) msg.push_back(8'h00);
    send_msg(msg);
    // zero-length attribute
    msg = {}; repeat (20) msg.push_back(8'hAA);
    msg.push_back(8'h80); msg.push_back(8'h22); msg.push_back(8'h00); msg.push_back(8'h00);
    send_msg(msg);
    drain();
    write_reg(RegHeaderInStream, 32'h0);
    write_reg(RegLocalPort, 32'hFFFF);
    write_reg(RegTid0, 32'hFFFFFFFF);
    write_reg(RegTid1, 32'h0);
    write_reg(RegTid2, 32'hA5A5_5A5A);
    // plain ipv4 mapped
    send_msg('{8'h00, 8'h01, 8'h00, 8'h08, 8'h00, 8'h01, 8'hFF, 8'hFF,
               8'hFF, 8'hFF, 8'hFF, 8'hFF});
    // same again: unchanged
    send_msg('{8'h00, 8'h01, 8'h00, 8'h08, 8'h00, 8'h01, 8'hFF, 8'hFF,
               8'hFF, 8'hFF, 8'hFF, 8'hFF});
    // xor ipv6 after a padded unknown attribute
    v6 = '{8'h80, 8'h22, 8'h00, 8'h01, 8'h7F, 8'h00, 8'h00, 8'h00,
           8'h00, 8'h20, 8'h00, 8'h14, 8'h00, 8'h02, 8'h00, 8'h00};
    repeat (16) v6.push_back(8'($urandom));
    v6.push_back(8'h00);
    send_msg(v6);
    // bad family, short mapped attr (family missing)
    send_msg('{8'h00, 8'h20, 8'h00, 8'h01, 8'h00, 8'h00});
    send_msg('{8'h00, 8'h01, 8'h00, 8'h08, 8'h00, 8'h07, 8'h12, 8'h34,
               8'h00, 8'h00, 8'h00, 8'h00});
    // oversize: mapped attr past the limit is ignored
    msg = {};
    msg.push_back(8'h80); msg.push_back(8'h00); msg.push_back(8'h07); msg.push_back(8'hFC);
    repeat (2044) msg.push_back(8'h55);
    msg.push_back(8'h00); msg.push_back(8'h01); msg.push_back(8'h00); msg.push_back(8'h08);
    repeat (8) msg.push_back(8'h01);
    send_msg(msg);
    drain();
    write_reg(RegHeaderInStream, 32'h1);
    write_reg(RegLocalPort, 32'h0);

    // random part in three idle regimes with register changes between them
    for (int phase_n = 0; phase_n < 3; phase_n++) begin
      send_idle_pct = (phase_n == 0) ? 25 : (phase_n == 1) ? 83 : 0;
      recv_idle_pct = (phase_n == 0) ? 83 : (phase_n == 1) ? 25 : 0;
      for (int sub = 0; sub < 4; sub++) begin
        drain();
        write_reg(RegHeaderInStream, 32'($urandom_range(1)));
        write_reg(RegLocalPort, (sub == 0) ? 32'hFFFF : (sub == 1) ? 32'h0 : $urandom);
        write_reg(RegTid0, (sub == 0) ? 32'hFFFFFFFF : $urandom);
        write_reg(RegTid1, (sub == 0) ? 32'hFFFFFFFF : $urandom);
        write_reg(RegTid2, (sub == 1) ? 32'h0 : $urandom);
        k = 0;
        while (k < 100) begin
          build_msg(msg, cfg_skip_header);
          send_msg(msg);
          k += msg.size();
        end
      end
    end
    drain();
    if (mismatches == 0) begin
      $display("tb_stun_mapped_address_parser passed");
    end else begin
      $display("tb_stun_mapped_address_parser failed");
    end
    $finish;
  end

endmodule
